>>> design/brng_pkg.sv
`default_nettype none

package brng_pkg;

  // Sequencer states of the bitmap engine.
  typedef enum logic [3:0] {
    ST_INIT,    // zero sweep after reset
    ST_IDLE,    // waiting for a request
    ST_SET_RD,  // read one word of a set range
    ST_SET_WR,  // merge the edge mask into that word and write it back
    ST_CLR,     // zero one word of a clear
    ST_OR_RD,   // read the word addressed by an OR
    ST_OR_WR,   // merge the source word and write it back
    ST_RD,      // fetch the word that the result reports
    ST_RES      // hand the result to the output register
  } state_t;

  // Request codes carried in the action field.
  localparam logic [1:0] ACT_SET = 2'd0;
  localparam logic [1:0] ACT_CLR = 2'd1;
  localparam logic [1:0] ACT_OR  = 2'd2;
  localparam logic [1:0] ACT_RD  = 2'd3;

  localparam logic [31:0] WORD_ONES = 32'hffff_ffff;

endpackage

`default_nettype wire

>>> design/bitmap_range_engine_top.sv
// Flow: a range error goes straight to the result; other requests first update
// the words they touch (OR, clear, set range), then read the word they report;
// the result then waits on out_tready while an earlier one has not been taken.
// Throughput: one request at a time; the single memory port and the mask/merge
// unit visit one word at a time, and a set range reads each word, then writes it.
// Reset: rst_n is synchronous, active low; afterwards a zero sweep writes all
// MAP_WORDS words, one per cycle, and no request is taken until it ends.
`default_nettype none

module bitmap_range_engine_top #(
  parameter int MAP_WORDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata, from bit 0 up: action[1:0], first_bit[16:2], bit_count[32:17],
  // word_index[42:33], src_word[74:43], zero padding[79:75].
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,
  // out_tdata, from bit 0 up: read_word[31:0], range_error[32],
  // zero padding[39:33].
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata
);

  // Address width of the word store; kept at least one bit wide.
  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned LIMIT_BITS = MAP_WORDS * 32;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);

  // Request fields.
  logic [1:0]  action;
  logic [14:0] first_bit;
  logic [15:0] bit_count;
  logic [9:0]  word_index;
  logic [31:0] src_word;

  assign action     = in_tdata[1:0];
  assign first_bit  = in_tdata[16:2];
  assign bit_count  = in_tdata[32:17];
  assign word_index = in_tdata[42:33];
  assign src_word   = in_tdata[74:43];

  // Decode of a new request. The last bit index stays below 2^17, and the
  // number of words covered by a clear below 2^12.
  logic [16:0] last_bit;
  logic [16:0] count_up;
  logic [11:0] clr_words;
  logic [9:0]  first_word;
  logic [11:0] last_word;
  logic        first_word_ok;
  logic        set_err;
  logic        clr_err;
  logic        idx_err;

  assign last_bit      = 17'(first_bit) + 17'(bit_count) - 17'd1;
  assign count_up      = 17'(bit_count) + 17'd31;
  assign clr_words     = count_up[16:5];
  assign first_word    = first_bit[14:5];
  assign last_word     = last_bit[16:5];
  assign first_word_ok = 32'(first_word) < 32'(MAP_WORDS);
  assign set_err       = 32'(last_bit) >= LIMIT_BITS;
  assign clr_err       = 32'(clr_words) > 32'(MAP_WORDS);
  assign idx_err       = 32'(word_index) >= 32'(MAP_WORDS);

  // Sequencer registers.
  brng_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;      // word being visited
  logic [AW-1:0] end_r, end_nxt;        // last word of the walk
  logic [AW-1:0] ws_r, ws_nxt;          // first word of a set range
  logic [4:0]    first_lo_r, first_lo_nxt;
  logic [4:0]    last_lo_r, last_lo_nxt;
  logic [31:0]   src_r, src_nxt;
  logic          err_r, err_nxt;        // result is a range error
  logic          zero_r, zero_nxt;      // result word is zero without a read

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_word_r, out_word_nxt;
  logic        out_err_r, out_err_nxt;

  // Word store, one port: one write or one read per cycle, read data
  // registered.
  logic [31:0]   mem [MAP_WORDS];
  logic          mem_we;
  logic          mem_re;
  logic [31:0]   mem_wdata;
  logic [31:0]   rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[addr_r];
    end
  end

  // Mask and merge unit of a set range. The first word of a set range keeps the
  // bits before first_bit, the last word keeps the bits after the last bit.
  logic [31:0] lmask;
  logic [31:0] rmask;
  logic [31:0] set_mask;

  assign lmask    = (addr_r == ws_r) ? (brng_pkg::WORD_ONES >> first_lo_r)
                                     : brng_pkg::WORD_ONES;
  assign rmask    = (addr_r == end_r) ? (brng_pkg::WORD_ONES << (5'd31 - last_lo_r))
                                      : brng_pkg::WORD_ONES;
  assign set_mask = lmask & rmask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brng_pkg::ST_INIT;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r      <= end_nxt;
    ws_r       <= ws_nxt;
    first_lo_r <= first_lo_nxt;
    last_lo_r  <= last_lo_nxt;
    src_r      <= src_nxt;
    err_r      <= err_nxt;
    zero_r     <= zero_nxt;
    out_word_r <= out_word_nxt;
    out_err_r  <= out_err_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    end_nxt       = end_r;
    ws_nxt        = ws_r;
    first_lo_nxt  = first_lo_r;
    last_lo_nxt   = last_lo_r;
    src_nxt       = src_r;
    err_nxt       = err_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_err_nxt   = out_err_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_wdata     = '0;
    in_tready     = 1'b0;

    // The consumer takes the waiting result.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      brng_pkg::ST_INIT: begin
        mem_we = 1'b1;
        if (addr_r == LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = brng_pkg::ST_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end

      brng_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          err_nxt      = 1'b0;
          zero_nxt     = 1'b0;
          first_lo_nxt = first_bit[4:0];
          last_lo_nxt  = last_bit[4:0];
          ws_nxt       = AW'(first_word);
          end_nxt      = AW'(last_word);
          src_nxt      = src_word;
          unique case (action)
            brng_pkg::ACT_SET: begin
              if (bit_count == 16'd0) begin
                // Nothing to set: report the word holding first_bit, or zero past the map.
                addr_nxt = AW'(first_word);
                if (first_word_ok) begin
                  state_nxt = brng_pkg::ST_RD;
                end else begin
                  zero_nxt  = 1'b1;
                  state_nxt = brng_pkg::ST_RES;
                end
              end else if (set_err) begin
                err_nxt   = 1'b1;
                state_nxt = brng_pkg::ST_RES;
              end else begin
                addr_nxt  = AW'(first_word);
                state_nxt = brng_pkg::ST_SET_RD;
              end
            end
            brng_pkg::ACT_CLR: begin
              addr_nxt = '0;
              end_nxt  = AW'(clr_words - 12'd1);
              if (clr_err) begin
                err_nxt   = 1'b1;
                state_nxt = brng_pkg::ST_RES;
              end else if (clr_words == 12'd0) begin
                state_nxt = brng_pkg::ST_RD;
              end else begin
                state_nxt = brng_pkg::ST_CLR;
              end
            end
            brng_pkg::ACT_OR: begin
              addr_nxt = AW'(word_index);
              if (idx_err) begin
                err_nxt   = 1'b1;
                state_nxt = brng_pkg::ST_RES;
              end else begin
                state_nxt = brng_pkg::ST_OR_RD;
              end
            end
            brng_pkg::ACT_RD: begin
              addr_nxt = AW'(word_index);
              if (idx_err) begin
                err_nxt   = 1'b1;
                state_nxt = brng_pkg::ST_RES;
              end else begin
                state_nxt = brng_pkg::ST_RD;
              end
            end
            default: begin
              state_nxt = brng_pkg::ST_IDLE;
            end
          endcase
        end
      end

      brng_pkg::ST_SET_RD: begin
        mem_re    = 1'b1;
        state_nxt = brng_pkg::ST_SET_WR;
      end

      brng_pkg::ST_SET_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_r | set_mask;
        if (addr_r == end_r) begin
          // Walk done; report the first word after its update.
          addr_nxt  = ws_r;
          state_nxt = brng_pkg::ST_RD;
        end else begin
          addr_nxt  = addr_r + AW'(1);
          state_nxt = brng_pkg::ST_SET_RD;
        end
      end

      brng_pkg::ST_CLR: begin
        mem_we = 1'b1;
        if (addr_r == end_r) begin
          addr_nxt  = '0;
          state_nxt = brng_pkg::ST_RD;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end

      brng_pkg::ST_OR_RD: begin
        mem_re    = 1'b1;
        state_nxt = brng_pkg::ST_OR_WR;
      end

      brng_pkg::ST_OR_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_r | src_r;
        state_nxt = brng_pkg::ST_RD;
      end

      brng_pkg::ST_RD: begin
        mem_re    = 1'b1;
        state_nxt = brng_pkg::ST_RES;
      end

      brng_pkg::ST_RES: begin
        // Wait here while the previous result has not been taken.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_err_nxt   = err_r;
          out_word_nxt  = (err_r || zero_r) ? 32'd0 : rdata_r;
          state_nxt     = brng_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = brng_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_err_r, out_word_r};

  // A request is never taken right after another one has been taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken on back-to-back cycles");

  // The store is never written while the engine waits for a request.
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == brng_pkg::ST_IDLE |-> !mem_we)
    else $error("store written while idle");

  // An error result always reports a zero word.
  a_err_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_word_r == 32'd0)
    else $error("range error with nonzero word");

  // A set range walk stays between its first and last words.
  a_set_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == brng_pkg::ST_SET_WR |-> addr_r >= ws_r && addr_r <= end_r)
    else $error("set range walk left its bounds");

  // Writing back a set range word never loses a bit that was set.
  a_set_keeps_bits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == brng_pkg::ST_SET_WR |-> (mem_wdata & rdata_r) == rdata_r)
    else $error("set range dropped a bit");

endmodule

`default_nettype wire
